// ===== src/iff_pkg.sv =====
// ----------------------------------------------------------------------------
// iff_pkg
// Shared types and constants of the integer field formatter.
// ----------------------------------------------------------------------------
`default_nettype none
package iff_pkg;
  localparam int unsigned MaxFieldWidth     = 55;
  localparam int unsigned MaxDigitPrecision = 43;
  localparam int unsigned DigitMax          = 22;
  localparam int unsigned CntW              = 6;
  localparam int unsigned DigIdxW           = 5;

  typedef enum logic [1:0] {
    RADIX_OCT = 2'd0,
    RADIX_DEC = 2'd1,
    RADIX_HEX = 2'd2,
    RADIX_HX3 = 2'd3
  } radix_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_LPAD,
    ST_SIGN,
    ST_PFX0,
    ST_PFXX,
    ST_ZPAD,
    ST_PZERO,
    ST_DIGIT,
    ST_RPAD
  } state_e;

  typedef enum logic [2:0] {
    CH_SPACE,
    CH_SIGN,
    CH_ZERO,
    CH_X,
    CH_DIGIT
  } char_sel_e;

  typedef struct packed {
    logic      load;
    logic      div_step;
    logic      setup;
    char_sel_e sel;
    logic      last;
    logic      cnt_load_pad;
    logic      cnt_load_zeros;
    logic      cnt_dec;
    logic      dig_dec;
  } ctrl_t;

  typedef struct packed {
    logic            div_done;
    logic [CntW-1:0] cnt;
    logic            cnt_zero;
    logic            dig_one;
    logic            has_sign;
    logic [1:0]      plen;
    logic            zfill;
    logic            left;
    logic [CntW-1:0] pad;
  } status_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] r;
    if (d < 4'd10) r = 8'h30 + {4'd0, d};
    else r = (upper ? 8'h41 : 8'h61) + {4'd0, d} - 8'd10;
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== src/iff_stream_if.sv =====
// ----------------------------------------------------------------------------
// iff_in_if / iff_out_if
// Valid-ready channels of the formatter.
// ----------------------------------------------------------------------------
`default_nettype none
interface iff_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] raw_value;
  logic [2:0]  length_mode;
  logic [1:0]  radix_select;
  logic        upper_case;
  logic [5:0]  format_flags;
  logic [5:0]  field_width;
  logic [5:0]  digit_precision;
  modport source (output valid, raw_value, length_mode, radix_select, upper_case,
                  format_flags, field_width, digit_precision, input ready);
  modport sink (input valid, raw_value, length_mode, radix_select, upper_case,
                format_flags, field_width, digit_precision, output ready);
endinterface

interface iff_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;
  modport source (output valid, out_char, last_char, input ready);
  modport sink (input valid, out_char, last_char, output ready);
endinterface
`default_nettype wire

// ===== src/iff_datapath.sv =====
// ----------------------------------------------------------------------------
// iff_datapath
// Operand capture, radix division (one digit per cycle, decimal in two
// half-steps), field lengths and character selection.
// ----------------------------------------------------------------------------
`default_nettype none
module iff_datapath import iff_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [63:0] raw_value_i,
  input  wire logic [2:0]  length_mode_i,
  input  wire logic [1:0]  radix_select_i,
  input  wire logic        upper_case_i,
  input  wire logic [5:0]  format_flags_i,
  input  wire logic [5:0]  field_width_i,
  input  wire logic [5:0]  digit_precision_i,
  input  wire ctrl_t       ctrl_i,
  output status_t          status_o,
  output logic [7:0]       char_o
);
  logic [63:0] val_q, val_d;
  logic [3:0]  digs_q [DigitMax];
  logic [DigIdxW-1:0] nd_q, nd_d, di_q, di_d;
  logic [CntW-1:0] cnt_q, cnt_d, pad_q, pad_d, zeros_q, zeros_d;
  logic [CntW-1:0] width_q, prec_q;
  logic [1:0]  plen_q;
  logic        neg_q, plus_q, precg_q, zpad_q, left_q, upper_q, nz_q;
  logic        dph_q, dph_d;
  logic [31:0] hq_q;
  logic [3:0]  hr_q;
  radix_e      radix_q;

  logic [63:0] mask, tv, mag, quo;
  logic [3:0]  rem;
  logic        neg_n;
  radix_e      rin;
  logic [63:0] hprod;
  logic [31:0] hq_n;
  logic [3:0]  hr_n;
  logic [35:0] lx;
  logic [71:0] lprod;
  logic [31:0] lq;
  logic [3:0]  lr;
  logic        step_done;

  always_comb begin
    rin = radix_e'(radix_select_i);
    case (length_mode_i)
      3'd0:    mask = 64'hFF;
      3'd1:    mask = 64'hFFFF;
      3'd2,
      3'd3:    mask = 64'hFFFF_FFFF;
      default: mask = '1;
    endcase
    tv = raw_value_i & mask;
    case (length_mode_i)
      3'd0:    neg_n = tv[7];
      3'd1:    neg_n = tv[15];
      3'd2,
      3'd3:    neg_n = tv[31];
      default: neg_n = tv[63];
    endcase
    neg_n = neg_n && format_flags_i[4] && (rin == RADIX_DEC);
    mag = neg_n ? ((64'd0 - tv) & mask) : tv;
  end

  // decimal: upper word divided by ten in the first half-step, then the
  // upper remainder joined to the lower word in the second
  always_comb begin
    hprod = {32'd0, val_q[63:32]} * 64'h0000_0000_CCCC_CCCD;
    hq_n  = {3'd0, hprod[63:35]};
    hr_n  = 4'(val_q[63:32] - hq_n * 32'd10);
    lx    = {hr_q, val_q[31:0]};
    lprod = {36'd0, lx} * 72'h0C_CCCC_CCCD;
    lq    = lprod[70:39];
    lr    = 4'(lx - {4'd0, lq} * 36'd10);
    step_done = ctrl_i.div_step && ((radix_q != RADIX_DEC) || dph_q);
    quo = '0;
    rem = '0;
    case (radix_q)
      RADIX_OCT: begin
        quo = val_q >> 3;
        rem = {1'b0, val_q[2:0]};
      end
      RADIX_DEC: begin
        quo = {hq_q, lq};
        rem = lr;
      end
      default: begin
        quo = val_q >> 4;
        rem = val_q[3:0];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      radix_q <= rin;
      upper_q <= upper_case_i;
      neg_q   <= neg_n;
      plus_q  <= format_flags_i[2];
      precg_q <= format_flags_i[5];
      zpad_q  <= format_flags_i[1];
      left_q  <= format_flags_i[0];
      nz_q    <= (mag != 64'd0);
      width_q <= (field_width_i > CntW'(MaxFieldWidth)) ? CntW'(MaxFieldWidth)
                                                          : field_width_i;
      prec_q  <= (digit_precision_i > CntW'(MaxDigitPrecision))
                 ? CntW'(MaxDigitPrecision) : digit_precision_i;
      plen_q  <= !format_flags_i[3] ? 2'd0 :
                 (rin == RADIX_OCT) ? 2'd1 : (rin == RADIX_DEC) ? 2'd0 : 2'd2;
    end
    if (ctrl_i.div_step && !dph_q) begin
      hq_q <= hq_n;
      hr_q <= hr_n;
    end
    if (step_done) digs_q[nd_q] <= rem;
  end

  logic [CntW-1:0] total, zraw, nd_w;
  always_comb begin
    val_d = val_q;
    nd_d  = nd_q;
    di_d  = di_q;
    cnt_d = cnt_q;
    pad_d = pad_q;
    zeros_d = zeros_q;
    dph_d = dph_q;
    nd_w  = CntW'(nd_q);
    zraw  = (prec_q > nd_w) ? prec_q - nd_w : '0;
    if (ctrl_i.load) begin
      val_d = mag;
      nd_d  = '0;
      dph_d = 1'b0;
    end else if (step_done) begin
      val_d = quo;
      nd_d  = nd_q + 1'b1;
      dph_d = 1'b0;
    end else if (ctrl_i.div_step) begin
      dph_d = 1'b1;
    end
    if (ctrl_i.setup) begin
      zeros_d = (nz_q && precg_q && zraw > CntW'(plen_q)) ? zraw - CntW'(plen_q) : '0;
      di_d = nd_q - 1'b1;
    end
    total = CntW'(status_o.has_sign) + CntW'(plen_q) + zeros_q + nd_w;
    if (ctrl_i.setup) begin
      total = CntW'(status_o.has_sign) + CntW'(plen_q) + zeros_d + nd_w;
      pad_d = (width_q > total) ? width_q - total : '0;
    end
    if (ctrl_i.setup) cnt_d = pad_d;
    else if (ctrl_i.cnt_load_pad) cnt_d = pad_q;
    else if (ctrl_i.cnt_load_zeros) cnt_d = zeros_q;
    else if (ctrl_i.cnt_dec) cnt_d = cnt_q - 1'b1;
    if (ctrl_i.dig_dec) di_d = di_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0; nd_q <= '0; di_q <= '0; cnt_q <= '0; pad_q <= '0; zeros_q <= '0;
      dph_q <= 1'b0;
    end else begin
      val_q <= val_d; nd_q <= nd_d; di_q <= di_d; cnt_q <= cnt_d;
      pad_q <= pad_d; zeros_q <= zeros_d;
      dph_q <= dph_d;
    end
  end

  always_comb begin
    status_o.div_done = (val_q == 64'd0) && (nd_q != '0);
    status_o.cnt      = cnt_q;
    status_o.cnt_zero = (cnt_q == '0);
    status_o.dig_one  = (di_q == '0);
    status_o.has_sign = neg_q || (plus_q && nz_q);
    status_o.plen     = plen_q;
    status_o.zfill    = zpad_q && !precg_q && !left_q;
    status_o.left     = left_q;
    status_o.pad      = pad_q;
    case (ctrl_i.sel)
      CH_SPACE: char_o = 8'h20;
      CH_SIGN:  char_o = neg_q ? 8'h2D : 8'h2B;
      CH_ZERO:  char_o = 8'h30;
      CH_X:     char_o = upper_q ? 8'h58 : 8'h78;
      CH_DIGIT: char_o = digit_char(digs_q[di_q], upper_q);
      default:  char_o = 8'h20;
    endcase
  end
endmodule
`default_nettype wire

// ===== src/iff_controller.sv =====
// ----------------------------------------------------------------------------
// iff_controller
// Sequencer: division, setup, then field sections, one beat per cycle within a section while the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none
module iff_controller import iff_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire status_t status_i,
  output ctrl_t        ctrl_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  logic more;
  always_comb begin
    state_d = state_q;
    ctrl_o = '0;
    ctrl_o.sel = CH_SPACE;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    more = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) state_d = ST_SETUP;
        else ctrl_o.div_step = 1'b1;
      end
      ST_SETUP: begin
        ctrl_o.setup = 1'b1;
        state_d = ST_LPAD;
      end
      ST_LPAD: begin
        state_d = ST_SIGN;
        if (!status_i.left && !status_i.zfill && status_i.pad != '0) begin
          ctrl_o.sel = CH_SPACE;
          out_valid_o = 1'b1;
          state_d = ST_LPAD;
          if (out_ready_i) begin
            ctrl_o.cnt_dec = 1'b1;
            if (status_i.cnt == CntW'(1)) state_d = ST_SIGN;
          end
        end
      end
      ST_SIGN: begin
        state_d = ST_PFX0;
        if (status_i.has_sign) begin
          ctrl_o.sel = CH_SIGN;
          out_valid_o = 1'b1;
          if (!out_ready_i) state_d = ST_SIGN;
        end
      end
      ST_PFX0: begin
        state_d = ST_PFXX;
        if (status_i.plen != 2'd0) begin
          ctrl_o.sel = CH_ZERO;
          out_valid_o = 1'b1;
          if (!out_ready_i) state_d = ST_PFX0;
        end
        if (state_d == ST_PFXX) ctrl_o.cnt_load_pad = 1'b1;
      end
      ST_PFXX: begin
        state_d = ST_ZPAD;
        if (status_i.plen == 2'd2) begin
          ctrl_o.sel = CH_X;
          out_valid_o = 1'b1;
          if (!out_ready_i) state_d = ST_PFXX;
        end
      end
      ST_ZPAD: begin
        if (status_i.zfill && !status_i.cnt_zero) begin
          ctrl_o.sel = CH_ZERO;
          out_valid_o = 1'b1;
          if (out_ready_i) ctrl_o.cnt_dec = 1'b1;
        end else begin
          ctrl_o.cnt_load_zeros = 1'b1;
          state_d = ST_PZERO;
        end
      end
      ST_PZERO: begin
        if (!status_i.cnt_zero) begin
          ctrl_o.sel = CH_ZERO;
          out_valid_o = 1'b1;
          if (out_ready_i) ctrl_o.cnt_dec = 1'b1;
        end else begin
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        ctrl_o.sel = CH_DIGIT;
        out_valid_o = 1'b1;
        more = status_i.left && status_i.pad != '0;
        ctrl_o.last = status_i.dig_one && !more;
        if (out_ready_i) begin
          if (status_i.dig_one) begin
            if (more) begin
              ctrl_o.cnt_load_pad = 1'b1;
              state_d = ST_RPAD;
            end else begin
              state_d = ST_IDLE;
            end
          end else begin
            ctrl_o.dig_dec = 1'b1;
          end
        end
      end
      ST_RPAD: begin
        ctrl_o.sel = CH_SPACE;
        out_valid_o = 1'b1;
        ctrl_o.last = (status_i.cnt == CntW'(1));
        if (out_ready_i) begin
          ctrl_o.cnt_dec = 1'b1;
          if (status_i.cnt == CntW'(1)) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== src/integer_field_formatter_unit.sv =====
// ----------------------------------------------------------------------------
// integer_field_formatter_unit
// Formats one printf-style integer conversion into a stream of characters.
// ----------------------------------------------------------------------------
// The input channel takes one conversion per beat: value, length mode,
// radix, case, flags, width and precision. The output channel gives one
// ASCII character per beat, last_char marking the end of the field.
// After a beat is taken the value is broken into digits: up to 22 for
// octal and hex, up to 20 for decimal, each decimal digit through an upper
// and a lower half-step, until the quotient is seen to reach zero.
// A setup step follows, then the field streams out (up to 55 characters)
// at one character per cycle while the receiver is ready, with steps
// without a beat as the sequencer moves between sections.
// A new conversion is taken only once the last character has gone.
// A stalled receiver freezes the stream; nothing is lost or repeated.
// Reset returns the sequencer to idle with nothing pending.
// ----------------------------------------------------------------------------
`default_nettype none
module integer_field_formatter_unit import iff_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  iff_in_if.sink     in_i,
  iff_out_if.source  out_o
);
  ctrl_t   ctrl;
  status_t status;
  logic [7:0] ch;

  iff_controller u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  iff_datapath u_dp (
    .clk_i, .rst_ni,
    .raw_value_i      (in_i.raw_value),
    .length_mode_i    (in_i.length_mode),
    .radix_select_i   (in_i.radix_select),
    .upper_case_i     (in_i.upper_case),
    .format_flags_i   (in_i.format_flags),
    .field_width_i    (in_i.field_width),
    .digit_precision_i(in_i.digit_precision),
    .ctrl_i           (ctrl),
    .status_o         (status),
    .char_o           (ch)
  );

  assign out_o.out_char  = ch;
  assign out_o.last_char = ctrl.last;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid)) else $error("input taken mid-field");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last_char) |=> in_i.ready)
    else $error("not idle after last beat");
`endif
endmodule
`default_nettype wire
